FILE: design/lavt_pkg.sv
package lavt_pkg;

	// Fixed-point format of every coordinate: signed Q16.16.
	localparam int unsigned Q_W  = 32;
	localparam int unsigned FRAC = 16;
	localparam logic signed [31:0] ONE_Q = 32'sd65536;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_POS_X = 3'd0,
		REG_POS_Y = 3'd1,
		REG_POS_Z = 3'd2,
		REG_DIR_X = 3'd3,
		REG_DIR_Y = 3'd4,
		REG_DIR_Z = 3'd5
	} reg_idx_t;

	localparam logic [2:0] NUM_REGS = 3'd6;

	// View matrix: m[row][col], rows 0..2 multiply vertex x, y, z and row 3 multiplies w.
	// Columns 0, 1, 2 hold right, up and forward.
	typedef struct packed {
		logic                        degenerate;
		logic [3:0][2:0][Q_W-1:0]    m;
	} matrix_t;

	// Shift right by the fraction width with rounding half toward plus infinity.
	function automatic logic signed [65:0] rnd16(input logic signed [65:0] x);
		return (x + 66'sd32768) >>> FRAC;
	endfunction

	// Saturate to a signed width of w bits (w at most 32), returned sign-extended to 32 bits.
	function automatic logic signed [31:0] sat_q(input logic signed [65:0] x, input int unsigned w);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = (66'sd1 <<< (w - 1)) - 66'sd1;
		lo = -hi - 66'sd1;
		if (x > hi) begin
			return hi[31:0];
		end else if (x < lo) begin
			return lo[31:0];
		end
		return x[31:0];
	endfunction

endpackage

FILE: design/lavt_fifo.sv
module lavt_fifo #(
	parameter int WIDTH = 129,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	assign full  = (count_q == (AW + 1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Storage is written only on a push; it needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/lavt_basis.sv
module lavt_basis #(
	parameter int SAT_W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                ready,
	output lavt_pkg::matrix_t   mat
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SQ_D,
		PH_SQRT_F,
		PH_DIV_F,
		PH_TV,
		PH_SQ_T,
		PH_SQRT_U,
		PH_DIV_U,
		PH_CROSS,
		PH_BOT
	} phase_t;

	phase_t             phase_q;
	logic               half_q;
	logic [1:0]         j_q;
	logic [1:0]         k_q;
	logic [4:0]         it_q;
	logic               deg_q;

	logic signed [31:0] pos_q [3];
	logic signed [31:0] dir_q [3];
	logic signed [31:0] f_q   [3];
	logic signed [31:0] t_q   [3];
	logic signed [31:0] u_q   [3];
	logic signed [31:0] r_q   [3];
	logic signed [31:0] bot_q [3];

	logic signed [63:0] prod_q;
	logic               mneg_q;
	logic signed [65:0] acc_q;

	logic [63:0]        sq_s_q;
	logic [63:0]        sq_r_q;
	logic [63:0]        sq_bit_q;
	logic [31:0]        len_q;

	logic [32:0]        rem_q;
	logic [17:0]        nlo_q;
	logic [17:0]        quo_q;
	logic               dneg_q;

	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic               op_neg;
	logic               last_term;
	logic               last_res;
	logic signed [65:0] acc_nx;
	logic signed [65:0] rnd_acc;

	logic [63:0]        sq_sum;
	logic               sq_ge;
	logic [63:0]        sq_r_nx;

	logic signed [31:0] div_src;
	logic [32:0]        div_ext;
	logic [32:0]        div_mag;
	logic [48:0]        div_num;
	logic [32:0]        div_den;
	logic [33:0]        trial;
	logic               trial_ge;
	logic [33:0]        trial_sub;
	logic [17:0]        quo_nx;
	logic signed [31:0] quo_signed;

	logic               cfg_hit;

	function automatic logic [1:0] nx3(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	assign cfg_hit = cfg_we && (cfg_index < lavt_pkg::NUM_REGS);
	assign ready   = (phase_q == PH_IDLE);

	// Operand selection for the shared multiplier, by phase, result row and term.
	always_comb begin
		op_a      = '0;
		op_b      = '0;
		op_neg    = 1'b0;
		last_term = 1'b1;
		last_res  = 1'b1;
		case (phase_q)
			PH_SQ_D: begin
				op_a      = dir_q[k_q];
				op_b      = dir_q[k_q];
				last_term = (k_q == 2'd2);
			end
			PH_SQ_T: begin
				op_a      = t_q[k_q];
				op_b      = t_q[k_q];
				last_term = (k_q == 2'd2);
			end
			PH_TV: begin
				op_a     = f_q[j_q];
				op_b     = f_q[1];
				last_res = (j_q == 2'd2);
			end
			PH_CROSS: begin
				if (k_q == 2'd0) begin
					op_a = u_q[nx3(j_q)];
					op_b = f_q[nx3(nx3(j_q))];
				end else begin
					op_a   = u_q[nx3(nx3(j_q))];
					op_b   = f_q[nx3(j_q)];
					op_neg = 1'b1;
				end
				last_term = (k_q == 2'd1);
				last_res  = (j_q == 2'd2);
			end
			PH_BOT: begin
				op_a = pos_q[k_q];
				case (j_q)
					2'd0:    op_b = r_q[k_q];
					2'd1:    op_b = u_q[k_q];
					default: op_b = f_q[k_q];
				endcase
				last_term = (k_q == 2'd2);
				last_res  = (j_q == 2'd2);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign acc_nx  = acc_q + (mneg_q ? -66'(prod_q) : 66'(prod_q));
	assign rnd_acc = lavt_pkg::rnd16(acc_nx);

	// One step of the bit-pair square root.
	assign sq_sum  = sq_r_q + sq_bit_q;
	assign sq_ge   = (sq_s_q >= sq_sum);
	assign sq_r_nx = sq_ge ? ((sq_r_q >> 1) + sq_bit_q) : (sq_r_q >> 1);

	// One step of the restoring division (2*|v|*2^16 + len) / (2*len).
	assign div_src    = (phase_q == PH_DIV_F) ? dir_q[j_q] : t_q[j_q];
	assign div_ext    = {div_src[31], div_src};
	assign div_mag    = div_src[31] ? (33'd0 - div_ext) : div_ext;
	assign div_num    = {div_mag[31:0], 17'd0} + {17'd0, len_q};
	assign div_den    = {len_q, 1'b0};
	assign trial      = {rem_q, nlo_q[17]};
	assign trial_ge   = (trial >= {1'b0, div_den});
	assign trial_sub  = trial - {1'b0, div_den};
	assign quo_nx     = {quo_q[16:0], trial_ge};
	assign quo_signed = dneg_q ? -$signed({14'd0, quo_nx}) : $signed({14'd0, quo_nx});

	// Matrix columns are right, up and forward; row three is the translation.
	always_comb begin
		mat.degenerate = deg_q;
		for (int i = 0; i < 3; i++) begin
			mat.m[i][0] = r_q[i];
			mat.m[i][1] = u_q[i];
			mat.m[i][2] = f_q[i];
			mat.m[3][i] = bot_q[i];
		end
	end

	// Basis sequencer: restarts on every register write and runs to idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SQ_D;
			half_q   <= 1'b0;
			j_q      <= '0;
			k_q      <= '0;
			it_q     <= '0;
			deg_q    <= 1'b0;
			acc_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				dir_q[i] <= '0;
			end
			dir_q[2] <= lavt_pkg::ONE_Q;
		end else if (cfg_hit) begin
			case (lavt_pkg::reg_idx_t'(cfg_index))
				lavt_pkg::REG_POS_X: pos_q[0] <= cfg_data;
				lavt_pkg::REG_POS_Y: pos_q[1] <= cfg_data;
				lavt_pkg::REG_POS_Z: pos_q[2] <= cfg_data;
				lavt_pkg::REG_DIR_X: dir_q[0] <= cfg_data;
				lavt_pkg::REG_DIR_Y: dir_q[1] <= cfg_data;
				lavt_pkg::REG_DIR_Z: dir_q[2] <= cfg_data;
				default:             dir_q[2] <= dir_q[2];
			endcase
			phase_q <= PH_SQ_D;
			half_q  <= 1'b0;
			j_q     <= '0;
			k_q     <= '0;
			acc_q   <= '0;
			deg_q   <= 1'b0;
		end else begin
			case (phase_q)
				PH_SQ_D, PH_SQ_T, PH_TV, PH_CROSS, PH_BOT: begin
					if (!half_q) begin
						prod_q <= op_a * op_b;
						mneg_q <= op_neg;
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						if (!last_term) begin
							acc_q <= acc_nx;
							k_q   <= k_q + 2'd1;
						end else begin
							acc_q <= '0;
							k_q   <= '0;
							j_q   <= last_res ? 2'd0 : j_q + 2'd1;
							case (phase_q)
								PH_SQ_D, PH_SQ_T: begin
									sq_s_q   <= acc_nx[63:0];
									sq_r_q   <= '0;
									sq_bit_q <= 64'h4000_0000_0000_0000;
									it_q     <= '0;
									phase_q  <= (phase_q == PH_SQ_D) ? PH_SQRT_F : PH_SQRT_U;
								end
								PH_TV: begin
									t_q[j_q] <= ((j_q == 2'd1) ? lavt_pkg::ONE_Q : 32'sd0)
										- rnd_acc[31:0];
									if (last_res) begin
										phase_q <= PH_SQ_T;
									end
								end
								PH_CROSS: begin
									r_q[j_q] <= rnd_acc[31:0];
									if (last_res) begin
										phase_q <= PH_BOT;
									end
								end
								default: begin
									bot_q[j_q] <= lavt_pkg::sat_q(-rnd_acc, SAT_W);
									if (last_res) begin
										phase_q <= PH_IDLE;
									end
								end
							endcase
						end
					end
				end
				PH_SQRT_F, PH_SQRT_U: begin
					if (sq_ge) begin
						sq_s_q <= sq_s_q - sq_sum;
					end
					sq_r_q   <= sq_r_nx;
					sq_bit_q <= sq_bit_q >> 2;
					it_q     <= it_q + 5'd1;
					if (it_q == 5'd31) begin
						len_q <= sq_r_nx[31:0];
						it_q  <= '0;
						j_q   <= '0;
						half_q <= 1'b0;
						if (sq_r_nx == '0) begin
							deg_q   <= 1'b1;
							phase_q <= PH_IDLE;
						end else begin
							phase_q <= (phase_q == PH_SQRT_F) ? PH_DIV_F : PH_DIV_U;
						end
					end
				end
				PH_DIV_F, PH_DIV_U: begin
					if (!half_q) begin
						rem_q  <= {2'd0, div_num[48:18]};
						nlo_q  <= div_num[17:0];
						quo_q  <= '0;
						dneg_q <= div_src[31];
						it_q   <= '0;
						half_q <= 1'b1;
					end else begin
						rem_q <= trial_ge ? trial_sub[32:0] : trial[32:0];
						nlo_q <= {nlo_q[16:0], 1'b0};
						quo_q <= quo_nx;
						it_q  <= it_q + 5'd1;
						if (it_q == 5'd17) begin
							if (phase_q == PH_DIV_F) begin
								f_q[j_q] <= quo_signed;
							end else begin
								u_q[j_q] <= quo_signed;
							end
							half_q <= 1'b0;
							it_q   <= '0;
							if (j_q == 2'd2) begin
								j_q     <= '0;
								phase_q <= (phase_q == PH_DIV_F) ? PH_TV : PH_CROSS;
							end else begin
								j_q <= j_q + 2'd1;
							end
						end
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/lavt_xform.sv
module lavt_xform #(
	parameter int SAT_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [3:0][31:0]     in_vertex,
	input  logic                 in_deg,
	output logic                 in_ready,
	input  lavt_pkg::matrix_t    mat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0][31:0]     out_view,
	output logic                 out_deg
);

	logic               adv;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_q;
	logic               deg_s1;
	logic               deg_s2;
	logic               deg_q;
	logic signed [63:0] prod_s1 [3][4];
	logic signed [65:0] sum_s2  [3];
	logic [2:0][31:0]   view_q;

	// The whole pipe moves together whenever the output word is free or being taken.
	assign adv       = !valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = valid_q;
	assign out_view  = view_q;
	assign out_deg   = deg_q;

	// Stage 1 forms the twelve vertex-by-matrix products, stage 2 sums each column,
	// the output stage rounds and saturates, or gives zero when the vertex is tagged degenerate.
	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s1 <= in_deg;
			for (int c = 0; c < 3; c++) begin
				for (int i = 0; i < 4; i++) begin
					prod_s1[c][i] <= $signed(in_vertex[i]) * $signed(mat.m[i][c]);
				end
			end
			deg_s2 <= deg_s1;
			for (int c = 0; c < 3; c++) begin
				sum_s2[c] <= 66'(prod_s1[c][0]) + 66'(prod_s1[c][1])
					+ 66'(prod_s1[c][2]) + 66'(prod_s1[c][3]);
			end
			deg_q <= deg_s2;
			for (int c = 0; c < 3; c++) begin
				view_q[c] <= deg_s2 ? 32'd0
					: lavt_pkg::sat_q(lavt_pkg::rnd16(sum_s2[c]), SAT_W);
			end
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

endmodule

FILE: design/look_at_view_transform_unit.sv
// Look-at view transform: each input word is one Q16.16 vertex (x, y, z, w) and each output
// word its camera-space x, y, z, saturated, with tuser set when the camera basis is degenerate
// (zero direction, or direction along world up), in which case the coordinates are zero.
// Vertices stream at one per cycle when nothing stalls, through a four-word queue and then the
// product, sum and output registers of the arithmetic pipeline. The camera basis is
// rebuilt by a shared multiplier, square-root and divider sequencer after reset and after each
// register write, with square roots of 32 steps and divides of 18 steps per component; it
// stops early if the direction turns out degenerate, and s_tready stays low meanwhile.
module look_at_view_transform_unit #(
	parameter int DATA_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [127:0]  s_tdata,   // vertex_x, vertex_y, vertex_z, vertex_w
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [95:0]   m_tdata,   // view_x, view_y, view_z
	output logic          m_tuser    // degenerate
);

	localparam int SAT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

	lavt_pkg::matrix_t mat;
	logic              basis_ready;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	logic [128:0]      q_rdata;
	logic              xf_ready;
	logic [2:0][31:0]  view;

	// Front: take a vertex when the basis is current and the queue has room,
	// tagging it with the degenerate flag.
	assign s_tready = basis_ready && !q_full;
	assign q_pop    = xf_ready && !q_empty;

	lavt_basis #(.SAT_W(SAT_W)) u_basis (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ready     (basis_ready),
		.mat       (mat)
	);

	lavt_fifo #(.WIDTH(129), .DEPTH(4)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (s_tvalid && s_tready),
		.wdata  ({mat.degenerate, s_tdata}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	lavt_xform #(.SAT_W(SAT_W)) u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!q_empty),
		.in_vertex (q_rdata[127:0]),
		.in_deg    (q_rdata[128]),
		.in_ready  (xf_ready),
		.mat       (mat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_view  (view),
		.out_deg   (m_tuser)
	);

	assign m_tdata = view;

endmodule

FILE: design/lavt_checker.sv
module lavt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_we,
	input logic [2:0]   cfg_index,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [95:0]  m_tdata,
	input logic         m_tuser
);

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// A degenerate camera gives zero coordinates.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 96'd0)
		else $error("degenerate word with nonzero coordinates");

	// A register write sends the basis off to be rebuilt, so input closes.
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index < lavt_pkg::NUM_REGS) |=> !s_tready)
		else $error("input open right after a register write");

endmodule

bind look_at_view_transform_unit lavt_checker u_lavt_checker (.*);

FILE: bench/tb_look_at_view_transform_unit.sv
`timescale 1ns / 100ps

module tb_look_at_view_transform_unit;

	typedef struct packed {
		logic        degenerate;
		logic [31:0] vz;
		logic [31:0] vy;
		logic [31:0] vx;
	} view_t;

	localparam int STALL_LIMIT = 4000;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic         m_tuser;

	// Camera registers as the predictor sees them.
	longint cam_reg [6];

	logic [127:0] vertex_queue [$];
	view_t        view_queue [$];
	int           fail_count;
	int           idle_cycles;
	int           src_wait;
	int           snk_wait;
	bit           no_gaps;

	look_at_view_transform_unit #(.DATA_WIDTH(32)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [95:0] mul96(input longint a, input longint b);
		logic signed [95:0] x;
		logic signed [95:0] y;
		x = a;
		y = b;
		return x * y;
	endfunction

	// Drop 16 fraction bits, ties toward plus infinity.
	function automatic logic signed [95:0] round_q(input logic signed [95:0] x);
		return (x + 96'sd32768) >>> 16;
	endfunction

	function automatic longint clamp32(input logic signed [95:0] x);
		if (x > 96'sd2147483647) begin
			return 64'sd2147483647;
		end else if (x < -96'sd2147483648) begin
			return -64'sd2147483648;
		end
		return longint'(x);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned abs_q(input longint a);
		return (a < 0) ? longint'(-a) : a;
	endfunction

	// Scale a vector to unit length; returns 0 when its length is zero.
	function automatic bit unit_vector(input longint a0, input longint a1, input longint a2,
			output longint o0, output longint o1, output longint o2);
		longint unsigned len;
		longint unsigned q [3];
		longint a [3];
		a[0] = a0;
		a[1] = a1;
		a[2] = a2;
		len = int_sqrt(abs_q(a0) * abs_q(a0) + abs_q(a1) * abs_q(a1) + abs_q(a2) * abs_q(a2));
		o0 = 0;
		o1 = 0;
		o2 = 0;
		if (len == 0) begin
			return 1'b0;
		end
		for (int i = 0; i < 3; i++) begin
			q[i] = (2 * (abs_q(a[i]) << 16) + len) / (2 * len);
		end
		o0 = (a0 < 0) ? -longint'(q[0]) : longint'(q[0]);
		o1 = (a1 < 0) ? -longint'(q[1]) : longint'(q[1]);
		o2 = (a2 < 0) ? -longint'(q[2]) : longint'(q[2]);
		return 1'b1;
	endfunction

	// Camera-space coordinates of one vertex under the current camera registers.
	function automatic view_t view_of_vertex(input logic [127:0] d);
		longint f [3];
		longint u [3];
		longint r [3];
		longint bot [3];
		longint v [4];
		longint p [3];
		longint dy;
		bit ok;
		view_t res;
		for (int i = 0; i < 4; i++) v[i] = longint'($signed(d[32*i +: 32]));
		for (int i = 0; i < 3; i++) p[i] = cam_reg[lavt_pkg::REG_POS_X + i];
		res = '0;
		ok = unit_vector(cam_reg[lavt_pkg::REG_DIR_X], cam_reg[lavt_pkg::REG_DIR_Y],
			cam_reg[lavt_pkg::REG_DIR_Z], f[0], f[1], f[2]);
		if (ok) begin
			// Gram-Schmidt against world up (0, 1, 0).
			dy = longint'(round_q(mul96(65536, f[1])));
			ok = unit_vector(-longint'(round_q(mul96(f[0], dy))),
				65536 - longint'(round_q(mul96(f[1], dy))),
				-longint'(round_q(mul96(f[2], dy))), u[0], u[1], u[2]);
		end
		if (!ok) begin
			res.degenerate = 1'b1;
			return res;
		end
		r[0] = longint'(round_q(mul96(u[1], f[2]) - mul96(u[2], f[1])));
		r[1] = longint'(round_q(mul96(u[2], f[0]) - mul96(u[0], f[2])));
		r[2] = longint'(round_q(mul96(u[0], f[1]) - mul96(u[1], f[0])));
		bot[0] = clamp32(-round_q(mul96(p[0], r[0]) + mul96(p[1], r[1]) + mul96(p[2], r[2])));
		bot[1] = clamp32(-round_q(mul96(p[0], u[0]) + mul96(p[1], u[1]) + mul96(p[2], u[2])));
		bot[2] = clamp32(-round_q(mul96(p[0], f[0]) + mul96(p[1], f[1]) + mul96(p[2], f[2])));
		res.vx = 32'(clamp32(round_q(mul96(v[0], r[0]) + mul96(v[1], r[1])
			+ mul96(v[2], r[2]) + mul96(v[3], bot[0]))));
		res.vy = 32'(clamp32(round_q(mul96(v[0], u[0]) + mul96(v[1], u[1])
			+ mul96(v[2], u[2]) + mul96(v[3], bot[1]))));
		res.vz = 32'(clamp32(round_q(mul96(v[0], f[0]) + mul96(v[1], f[1])
			+ mul96(v[2], f[2]) + mul96(v[3], bot[2]))));
		return res;
	endfunction

	function automatic int draw_wait();
		return no_gaps ? 0 : $urandom_range(5, 0);
	endfunction

	// Source side: offer queued vertices and record the expected view of each word taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_wait <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				view_queue.push_back(view_of_vertex(s_tdata));
			end
			if (!s_tvalid || s_tready) begin
				if (src_wait > 0) begin
					src_wait <= src_wait - 1;
					s_tvalid <= 1'b0;
				end else if (vertex_queue.size() > 0) begin
					s_tdata  <= vertex_queue.pop_front();
					s_tvalid <= 1'b1;
					src_wait <= draw_wait();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: random back-pressure, compare each word with the oldest expected view.
	always @(posedge clk or negedge arst_n) begin
		view_t want;
		int w;
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (view_queue.size() == 0) begin
					$display("%0t: unexpected word %h user %b", $time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = view_queue.pop_front();
					if (m_tdata[31:0] !== want.vx) begin
						$display("%0t: view_x expected %h actual %h", $time, want.vx, m_tdata[31:0]);
						fail_count++;
					end
					if (m_tdata[63:32] !== want.vy) begin
						$display("%0t: view_y expected %h actual %h", $time, want.vy,
							m_tdata[63:32]);
						fail_count++;
					end
					if (m_tdata[95:64] !== want.vz) begin
						$display("%0t: view_z expected %h actual %h", $time, want.vz,
							m_tdata[95:64]);
						fail_count++;
					end
					if (m_tuser !== want.degenerate) begin
						$display("%0t: degenerate expected %b actual %b", $time,
							want.degenerate, m_tuser);
						fail_count++;
					end
				end
				w = draw_wait();
				if (w == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					snk_wait <= w - 1;
				end
			end else if (!m_tready) begin
				if (snk_wait == 0) begin
					m_tready <= 1'b1;
				end else begin
					snk_wait <= snk_wait - 1;
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (vertex_queue.size() != 0 || s_tvalid || view_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input longint val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 32'(val);
		if (idx < lavt_pkg::NUM_REGS) cam_reg[idx] = longint'($signed(32'(val)));
		@(posedge clk);
	endtask

	task automatic set_camera(input longint px, input longint py, input longint pz,
			input longint dx, input longint dy, input longint dz);
		wait_drained();
		write_reg(lavt_pkg::REG_POS_X, px);
		write_reg(lavt_pkg::REG_POS_Y, py);
		write_reg(lavt_pkg::REG_POS_Z, pz);
		write_reg(lavt_pkg::REG_DIR_X, dx);
		write_reg(lavt_pkg::REG_DIR_Y, dy);
		write_reg(lavt_pkg::REG_DIR_Z, dz);
		cfg_we <= 1'b0;
	endtask

	function automatic longint rand_coord();
		case ($urandom_range(3, 0))
			0: return longint'($signed($urandom()));
			1: return longint'($signed(32'($urandom_range(2097152, 0)))) - 1048576;
			2: return ($urandom_range(1, 0) ? 64'sd2147483647 : -64'sd2147483648);
			default: return longint'($signed(32'($urandom_range(20971520, 0)))) - 10485760;
		endcase
	endfunction

	task automatic add_vertex(input longint x, input longint y, input longint z,
			input longint w);
		vertex_queue.push_back({32'(w), 32'(z), 32'(y), 32'(x)});
	endtask

	task automatic add_random_vertices(input int n);
		for (int i = 0; i < n; i++) begin
			add_vertex(rand_coord(), rand_coord(), rand_coord(),
				($urandom_range(3, 0) == 0) ? rand_coord() : 65536);
		end
	endtask

	task automatic add_edge_vertices();
		add_vertex(0, 0, 0, 65536);
		add_vertex(65536, 131072, -196608, 65536);
		add_vertex(2147483647, 2147483647, 2147483647, 2147483647);
		add_vertex(-2147483648, -2147483648, -2147483648, -2147483648);
		add_vertex(2147483647, -2147483648, 0, 65536);
		add_vertex(-1, 1, -1, 0);
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		no_gaps     = 1'b0;
		foreach (cam_reg[i]) cam_reg[i] = 0;
		cam_reg[lavt_pkg::REG_DIR_Z] = 65536;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset camera, then the degenerate and extreme cameras.
		add_edge_vertices();
		set_camera(0, 0, 0, 0, 0, 0);
		add_edge_vertices();
		set_camera(65536, 0, 0, 0, 65536, 0);
		add_edge_vertices();
		set_camera(0, 0, 0, 0, -327680, 0);
		add_vertex(65536, 65536, 65536, 65536);
		// Nearly along world up, leaving a tiny remainder.
		set_camera(1000, 2000, 3000, 1, 16777216, 0);
		add_edge_vertices();
		set_camera(2147483647, -2147483648, 2147483647,
			-2147483648, 2147483647, -2147483648);
		add_edge_vertices();

		// Writes to indexes past the last register must be ignored.
		wait_drained();
		write_reg(lavt_pkg::NUM_REGS, 12345);
		write_reg(3'(lavt_pkg::NUM_REGS + 1), -1);
		cfg_we <= 1'b0;
		add_vertex(65536, 65536, 65536, 65536);

		// Random phases, each under a fresh camera.
		for (int ph = 0; ph < 10; ph++) begin
			no_gaps = (ph % 3 == 2);
			if (ph == 9) begin
				set_camera(-2147483648, 2147483647, -2147483648,
					2147483647, -2147483648, 2147483647);
			end else begin
				set_camera(rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord());
			end
			add_random_vertices(100);
		end

		wait_drained();
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/lavt_pkg.sv
design/lavt_fifo.sv
design/lavt_basis.sv
design/lavt_xform.sv
design/look_at_view_transform_unit.sv
design/lavt_checker.sv
bench/tb_look_at_view_transform_unit.sv
